### hw/rtl/owbm_pkg.sv
package owbm_pkg;

  localparam int unsigned TICK_W = 12;
  localparam int unsigned RECOVERY_TICKS_DEF = 5;

  localparam logic [11:0] RESET_LOW_DEF       = 12'd600;
  localparam logic [7:0]  RESET_SETTLE_DEF    = 8'd20;
  localparam logic [9:0]  PRESENCE_WINDOW_DEF = 10'd500;
  localparam logic [9:0]  PRESENCE_LIMIT_DEF  = 10'd480;
  localparam logic [5:0]  SHORT_LOW_DEF       = 6'd5;
  localparam logic [7:0]  READ_SAMPLE_DEF     = 8'd20;
  localparam logic [7:0]  READ_SLOT_DEF       = 8'd60;
  localparam logic [7:0]  WRITE_SLOT_DEF      = 8'd80;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_READ  = 2'd2,
    CMD_WRITE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    CFG_RESET_LOW       = 3'd0,
    CFG_RESET_SETTLE    = 3'd1,
    CFG_PRESENCE_WINDOW = 3'd2,
    CFG_PRESENCE_LIMIT  = 3'd3,
    CFG_SHORT_LOW       = 3'd4,
    CFG_READ_SAMPLE     = 3'd5,
    CFG_READ_SLOT       = 3'd6,
    CFG_WRITE_SLOT      = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_RST_LOW    = 4'd1,
    PH_RST_SETTLE = 4'd2,
    PH_RST_WATCH  = 4'd3,
    PH_READ       = 4'd4,
    PH_WRITE      = 4'd5
  } phase_e;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] write_byte;
    logic       line_level;
  } in_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_byte;
    logic       command_rejected;
  } out_item_t;

endpackage

### hw/rtl/one_wire_bus_master_unit.sv
// an accepted tick beat's result is registered in the output register, or in the skid entry while the output is stalled
// throughput: one tick beat per cycle while in_stall_o is low, all timing state updated by one pass of logic
// a two-entry output buffer lets a beat in while the previous result is stalled
// reset: asynchronous, bus phase idle, counters and flags cleared, timing registers
// return to their standard-speed defaults, output buffer emptied
module one_wire_bus_master_unit #(
  parameter int unsigned RECOVERY_TICKS = owbm_pkg::RECOVERY_TICKS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  owbm_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output owbm_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [11:0]         cfg_data_i
);
  import owbm_pkg::*;

  localparam int unsigned RecW = $clog2(256 + RECOVERY_TICKS);

  logic [11:0] reset_low_q;
  logic [7:0]  reset_settle_q;
  logic [9:0]  presence_window_q;
  logic [9:0]  presence_limit_q;
  logic [5:0]  short_low_q;
  logic [7:0]  read_sample_q;
  logic [7:0]  read_slot_q;
  logic [7:0]  write_slot_q;

  phase_e            phase_q, phase_d;
  logic [TICK_W-1:0] tick_q, tick_d;
  logic [2:0]        bit_q, bit_d;
  logic [7:0]        shift_q, shift_d;
  logic              low_seen_q, low_seen_d;
  logic              pres_flag_q, pres_flag_d;

  out_item_t out_q, skid_q, res;
  logic      out_valid_q, skid_valid_q;
  logic      accept;

  // effective state once a start command has been applied
  logic              start;
  phase_e            eff_phase;
  logic [TICK_W-1:0] eff_tick;
  logic [2:0]        eff_bit;
  logic [7:0]        eff_shift;
  logic              eff_low_seen;
  logic              eff_pres_flag;

  logic [11:0] rst_low_min;
  logic [7:0]  settle_min;
  logic [9:0]  window_min;
  logic [5:0]  short_min;
  logic [7:0]  sample_min;
  logic [7:0]  rslot_min;
  logic [7:0]  wslot_min;
  logic [8:0]  sample_at;
  logic [8:0]  sample_plus1;
  logic [8:0]  read_end;
  logic [7:0]  write_body;
  logic [RecW-1:0] write_end;
  logic [TICK_W:0] tc_inc;

  logic rst_low_end, settle_end, watch_end, read_slot_end, write_slot_end;
  logic sample_now, short_active, body_active;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i && !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_low_q       <= RESET_LOW_DEF;
      reset_settle_q    <= RESET_SETTLE_DEF;
      presence_window_q <= PRESENCE_WINDOW_DEF;
      presence_limit_q  <= PRESENCE_LIMIT_DEF;
      short_low_q       <= SHORT_LOW_DEF;
      read_sample_q     <= READ_SAMPLE_DEF;
      read_slot_q       <= READ_SLOT_DEF;
      write_slot_q      <= WRITE_SLOT_DEF;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_RESET_LOW:       reset_low_q       <= cfg_data_i;
        CFG_RESET_SETTLE:    reset_settle_q    <= cfg_data_i[7:0];
        CFG_PRESENCE_WINDOW: presence_window_q <= cfg_data_i[9:0];
        CFG_PRESENCE_LIMIT:  presence_limit_q  <= cfg_data_i[9:0];
        CFG_SHORT_LOW:       short_low_q       <= cfg_data_i[5:0];
        CFG_READ_SAMPLE:     read_sample_q     <= cfg_data_i[7:0];
        CFG_READ_SLOT:       read_slot_q       <= cfg_data_i[7:0];
        CFG_WRITE_SLOT:      write_slot_q      <= cfg_data_i[7:0];
      endcase
    end
  end

  // a zero length acts as one
  assign rst_low_min = (reset_low_q == '0) ? 12'd1 : reset_low_q;
  assign settle_min  = (reset_settle_q == '0) ? 8'd1 : reset_settle_q;
  assign window_min  = (presence_window_q == '0) ? 10'd1 : presence_window_q;
  assign short_min   = (short_low_q == '0) ? 6'd1 : short_low_q;
  assign sample_min  = (read_sample_q == '0) ? 8'd1 : read_sample_q;
  assign rslot_min   = (read_slot_q == '0) ? 8'd1 : read_slot_q;
  assign wslot_min   = (write_slot_q == '0) ? 8'd1 : write_slot_q;

  assign sample_at    = {3'b000, short_min} + {1'b0, sample_min};
  assign sample_plus1 = sample_at + 9'd1;
  assign read_end     = ({1'b0, rslot_min} < sample_plus1) ? sample_plus1 : {1'b0, rslot_min};
  assign write_body   = (wslot_min < {2'b00, short_min}) ? {2'b00, short_min} : wslot_min;
  assign write_end    = RecW'(write_body) + RecW'(RECOVERY_TICKS);

  assign start = (phase_q == PH_IDLE) && (in_data_i.command != CMD_TICK);

  always_comb begin
    eff_phase     = phase_q;
    eff_tick      = tick_q;
    eff_bit       = bit_q;
    eff_shift     = shift_q;
    eff_low_seen  = low_seen_q;
    eff_pres_flag = pres_flag_q;
    if (start) begin
      unique case (cmd_e'(in_data_i.command))
        CMD_RESET: eff_phase = PH_RST_LOW;
        CMD_READ:  eff_phase = PH_READ;
        CMD_WRITE: eff_phase = PH_WRITE;
        default:   eff_phase = PH_IDLE;
      endcase
      eff_tick      = '0;
      eff_bit       = '0;
      eff_shift     = (cmd_e'(in_data_i.command) == CMD_WRITE) ? in_data_i.write_byte : 8'd0;
      eff_low_seen  = 1'b0;
      eff_pres_flag = 1'b0;
    end
  end

  assign tc_inc         = {1'b0, eff_tick} + 13'd1;
  assign rst_low_end    = tc_inc >= {1'b0, rst_low_min};
  assign settle_end     = tc_inc >= {5'b0, settle_min};
  assign watch_end      = tc_inc >= {3'b0, window_min};
  assign read_slot_end  = tc_inc >= {4'b0, read_end};
  assign write_slot_end = tc_inc >= (TICK_W + 1)'(write_end);
  assign sample_now     = eff_tick == {3'b0, sample_at};
  assign short_active   = eff_tick < {6'b0, short_min};
  assign body_active    = eff_tick < {4'b0, write_body};

  // next state
  always_comb begin
    phase_d     = eff_phase;
    tick_d      = eff_tick;
    bit_d       = eff_bit;
    shift_d     = eff_shift;
    low_seen_d  = eff_low_seen;
    pres_flag_d = eff_pres_flag;
    unique case (eff_phase)
      PH_RST_LOW: begin
        tick_d = tc_inc[TICK_W-1:0];
        if (rst_low_end) begin
          phase_d = PH_RST_SETTLE;
          tick_d  = '0;
        end
      end
      PH_RST_SETTLE: begin
        tick_d = tc_inc[TICK_W-1:0];
        if (settle_end) begin
          phase_d = PH_RST_WATCH;
          tick_d  = '0;
        end
      end
      PH_RST_WATCH: begin
        if (!eff_low_seen && !in_data_i.line_level) begin
          low_seen_d  = 1'b1;
          pres_flag_d = eff_tick < {2'b0, presence_limit_q};
        end
        tick_d = tc_inc[TICK_W-1:0];
        if (watch_end) begin
          phase_d = PH_IDLE;
          tick_d  = '0;
        end
      end
      PH_READ: begin
        if (sample_now) begin
          shift_d = {in_data_i.line_level, eff_shift[7:1]};
        end
        tick_d = tc_inc[TICK_W-1:0];
        if (read_slot_end) begin
          tick_d = '0;
          if (eff_bit == 3'd7) begin
            phase_d = PH_IDLE;
            bit_d   = '0;
          end else begin
            bit_d = eff_bit + 3'd1;
          end
        end
      end
      PH_WRITE: begin
        tick_d = tc_inc[TICK_W-1:0];
        if (write_slot_end) begin
          tick_d  = '0;
          shift_d = {1'b0, eff_shift[7:1]};
          if (eff_bit == 3'd7) begin
            phase_d = PH_IDLE;
            bit_d   = '0;
          end else begin
            bit_d = eff_bit + 3'd1;
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  // result of this tick
  always_comb begin
    res                  = '0;
    res.command_rejected = (phase_q != PH_IDLE) && (in_data_i.command != CMD_TICK);
    res.busy_res         = eff_phase != PH_IDLE;
    unique case (eff_phase)
      PH_RST_LOW: begin
        res.drive_low = 1'b1;
      end
      PH_RST_WATCH: begin
        res.done_res = watch_end;
        res.presence = watch_end && pres_flag_d;
      end
      PH_READ: begin
        res.drive_low = short_active;
        if (read_slot_end && eff_bit == 3'd7) begin
          res.done_res  = 1'b1;
          res.read_byte = shift_d;
        end
      end
      PH_WRITE: begin
        res.drive_low = eff_shift[0] ? short_active : body_active;
        res.done_res  = write_slot_end && eff_bit == 3'd7;
      end
      default: begin
        res.drive_low = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      bit_q       <= '0;
      shift_q     <= '0;
      low_seen_q  <= 1'b0;
      pres_flag_q <= 1'b0;
    end else if (accept) begin
      phase_q     <= phase_d;
      tick_q      <= tick_d;
      bit_q       <= bit_d;
      shift_q     <= shift_d;
      low_seen_q  <= low_seen_d;
      pres_flag_q <= pres_flag_d;
    end
  end

  // output register with one skid beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res;
      end
    end else if (accept) begin
      skid_q <= res;
    end
  end

endmodule
